### hdl/dcd_pkg.sv
// dcd_pkg: shared constants and types of the double clap detector
// used by dcd_core, dcd_out_stage and the top level; depends on nothing

package dcd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_SAMPLES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP_SAMPLES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_FLOOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_CEILING  = 3'd5;

  // register and field widths
  localparam int LVL_W  = 16;
  localparam int GAP_W  = 20;
  localparam int FRAC_W = 8;
  localparam int AMB_W  = 24;

  // reset values
  localparam logic [LVL_W-1:0] THRESHOLD_RST = 16'd20000;
  localparam logic [GAP_W-1:0] COOLDOWN_RST  = 20'd24000;
  localparam logic [GAP_W-1:0] MIN_GAP_RST   = 20'd1920;
  localparam logic [GAP_W-1:0] MAX_GAP_RST   = 20'd11200;
  localparam logic [LVL_W-1:0] FLOOR_RST     = 16'd500;
  localparam logic [LVL_W-1:0] CEILING_RST   = 16'd10000;
  localparam logic [AMB_W-1:0] AMBIENT_RST   = 24'd256000;

  // ambient average weights in Q8: keep 251/256 of old, add 5/256 of peak
  localparam int AMB_KEEP   = 251;
  localparam int PEAK_GAIN  = 5 * 256;
  localparam int ROUND_HALF = 128;

  typedef struct packed {
    logic [LVL_W-1:0] frame_peak;
    logic [LVL_W-1:0] ambient_level;
    logic             spike;
    logic             double_clap;
  } res_t;

  // per-cycle step control between the stages
  typedef struct packed {
    logic advance;  // registered word is processed this cycle
    logic emit;     // and it closes a frame
  } step_t;

endpackage

### hdl/dcd_in_if.sv
// dcd_in_if: sample channel of the double clap detector
// depends on nothing

interface dcd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_end;

  modport source(output valid, output sample, output frame_end, input ready);
  modport sink(input valid, input sample, input frame_end, output ready);
endinterface

### hdl/dcd_out_if.sv
// dcd_out_if: per-frame result channel of the double clap detector
// depends on nothing

interface dcd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_peak;
  logic [15:0] ambient_level;
  logic        spike;
  logic        double_clap;

  modport source(output valid, output frame_peak, output ambient_level,
                 output spike, output double_clap, input ready);
  modport sink(input valid, input frame_peak, input ambient_level,
               input spike, input double_clap, output ready);
endinterface

### hdl/dcd_in_stage.sv
// dcd_in_stage: input register of the detector, one sample word deep
// depends on dcd_in_if

module dcd_in_stage #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dcd_in_if.sink                        in_if,
  input  logic                          slot_free,
  output logic                          word_valid,
  output logic signed [SAMPLE_BITS-1:0] word_sample,
  output logic                          word_frame_end,
  output logic                          advance
);

  logic                          valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          frame_end_r;
  logic                          take;

  // a frame end may only move on when the result register can take it
  assign advance     = valid_r && (!frame_end_r || slot_free);
  assign in_if.ready = !valid_r || advance;
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_r    <= in_if.sample;
      frame_end_r <= in_if.frame_end;
    end
  end

  assign word_valid     = valid_r;
  assign word_sample    = sample_r;
  assign word_frame_end = frame_end_r;

endmodule

### hdl/dcd_core.sv
// dcd_core: configuration registers, detector state and per-sample decision logic
// depends on dcd_pkg

module dcd_core #(
  parameter int SAMPLE_BITS  = 16,
  parameter int ELAPSED_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  dcd_pkg::step_t                   step,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  output dcd_pkg::res_t                    res
);

  localparam int PK_W   = SAMPLE_BITS;
  localparam int PROD_W = (32 > PK_W + 11) ? 32 : PK_W + 11;
  localparam int SUM_W  = PROD_W + 1;
  localparam int A_W    = SUM_W - dcd_pkg::FRAC_W;
  localparam int CMP_W  = (PK_W + 8 > dcd_pkg::AMB_W + 1) ? PK_W + 8 : dcd_pkg::AMB_W + 1;
  localparam int CNT_W  = (ELAPSED_BITS > dcd_pkg::GAP_W) ? ELAPSED_BITS : dcd_pkg::GAP_W;
  localparam int THR_W  = (PK_W > dcd_pkg::LVL_W) ? PK_W : dcd_pkg::LVL_W;

  logic [dcd_pkg::LVL_W-1:0] threshold_r, floor_r, ceiling_r;
  logic [dcd_pkg::GAP_W-1:0] cooldown_r, min_gap_r, max_gap_r;

  logic [PK_W-1:0]           running_peak_r;
  logic [dcd_pkg::AMB_W-1:0] ambient_r;
  logic [ELAPSED_BITS-1:0]   since_spike_r, since_trigger_r;

  logic [PK_W-1:0]           raw, mag, peak;
  logic [ELAPSED_BITS-1:0]   spk_inc, trg_inc;
  logic [SUM_W-1:0]          sum;
  logic [A_W-1:0]            avg, lo, hi, avg_clamped;
  logic [dcd_pkg::AMB_W-1:0] ambient_nxt;
  logic                      loud, above_ambient, cooled, gap_ok, spike, dbl;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= dcd_pkg::THRESHOLD_RST;
      cooldown_r  <= dcd_pkg::COOLDOWN_RST;
      min_gap_r   <= dcd_pkg::MIN_GAP_RST;
      max_gap_r   <= dcd_pkg::MAX_GAP_RST;
      floor_r     <= dcd_pkg::FLOOR_RST;
      ceiling_r   <= dcd_pkg::CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dcd_pkg::REG_PEAK_THRESHOLD:   threshold_r <= cfg_data[dcd_pkg::LVL_W-1:0];
        dcd_pkg::REG_COOLDOWN_SAMPLES: cooldown_r  <= cfg_data[dcd_pkg::GAP_W-1:0];
        dcd_pkg::REG_MIN_GAP_SAMPLES:  min_gap_r   <= cfg_data[dcd_pkg::GAP_W-1:0];
        dcd_pkg::REG_MAX_GAP_SAMPLES:  max_gap_r   <= cfg_data[dcd_pkg::GAP_W-1:0];
        dcd_pkg::REG_AMBIENT_FLOOR:    floor_r     <= cfg_data[dcd_pkg::LVL_W-1:0];
        dcd_pkg::REG_AMBIENT_CEILING:  ceiling_r   <= cfg_data[dcd_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    raw = sample;
    // most negative sample wraps to 2^(n-1), which still fits unsigned
    mag  = raw[PK_W-1] ? (~raw + 1'b1) : raw;
    peak = (mag > running_peak_r) ? mag : running_peak_r;

    spk_inc = (&since_spike_r)   ? since_spike_r   : since_spike_r + 1'b1;
    trg_inc = (&since_trigger_r) ? since_trigger_r : since_trigger_r + 1'b1;

    sum = SUM_W'(ambient_r) * SUM_W'(dcd_pkg::AMB_KEEP)
        + SUM_W'(peak) * SUM_W'(dcd_pkg::PEAK_GAIN)
        + SUM_W'(dcd_pkg::ROUND_HALF);
    avg = sum[SUM_W-1:dcd_pkg::FRAC_W];
    lo  = A_W'({floor_r, 8'd0});
    hi  = A_W'({ceiling_r, 8'd0});
    // when floor and ceiling cross, an average below the floor gets the floor, any other gets the ceiling
    if (avg < lo) begin
      avg_clamped = lo;
    end else if (avg > hi) begin
      avg_clamped = hi;
    end else begin
      avg_clamped = avg;
    end
    ambient_nxt = avg_clamped[dcd_pkg::AMB_W-1:0];

    loud          = THR_W'(peak) > THR_W'(threshold_r);
    above_ambient = CMP_W'({peak, 8'd0}) > CMP_W'({ambient_nxt, 1'b0});
    cooled        = CNT_W'(trg_inc) > CNT_W'(cooldown_r);
    gap_ok        = (CNT_W'(spk_inc) > CNT_W'(min_gap_r))
                 && (CNT_W'(spk_inc) < CNT_W'(max_gap_r));
    spike = loud && above_ambient && cooled;
    dbl   = spike && gap_ok;

    res.frame_peak    = dcd_pkg::LVL_W'(peak);
    res.ambient_level = ambient_nxt[dcd_pkg::AMB_W-1:dcd_pkg::FRAC_W];
    res.spike         = spike;
    res.double_clap   = dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_peak_r  <= '0;
      ambient_r       <= dcd_pkg::AMBIENT_RST;
      since_spike_r   <= '1;
      since_trigger_r <= '1;
    end else if (step.advance) begin
      if (step.emit) begin
        running_peak_r <= '0;
        ambient_r      <= ambient_nxt;
        if (dbl) begin
          // a double clap forgets the first spike and restarts the cooldown
          since_spike_r   <= '1;
          since_trigger_r <= '0;
        end else begin
          since_spike_r   <= spike ? '0 : spk_inc;
          since_trigger_r <= trg_inc;
        end
      end else begin
        running_peak_r  <= peak;
        since_spike_r   <= spk_inc;
        since_trigger_r <= trg_inc;
      end
    end
  end

endmodule

### hdl/dcd_out_stage.sv
// dcd_out_stage: result register driving the per-frame result channel
// depends on dcd_pkg and dcd_out_if

module dcd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  dcd_pkg::step_t step,
  input  dcd_pkg::res_t  res,
  output logic           slot_free,
  dcd_out_if.source      out_if
);

  logic          valid_r;
  dcd_pkg::res_t res_r;

  assign slot_free = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step.emit) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.emit) begin
      res_r <= res;
    end
  end

  assign out_if.valid         = valid_r;
  assign out_if.frame_peak    = res_r.frame_peak;
  assign out_if.ambient_level = res_r.ambient_level;
  assign out_if.spike         = res_r.spike;
  assign out_if.double_clap   = res_r.double_clap;

endmodule

### hdl/double_clap_detector_unit.sv
// double_clap_detector_unit: top level of the double clap detector
// depends on dcd_pkg, dcd_in_if, dcd_out_if, dcd_in_stage, dcd_core, dcd_out_stage
//
// Usage:
//   in_if carries one signed audio sample per word plus frame_end, set on the
//   last sample of a frame. out_if gives one word per frame end: the frame
//   peak magnitude, the clamped ambient level, and the spike and double clap
//   flags. Samples that do not end a frame give no result word.
//   Samples are taken at one per cycle unless a frame end waits on a
//   stalled receiver: a word sits in the input register while the peak,
//   ambient and gap decisions are made, and the result then lands in the
//   output register, so each result passes the input and then the output register.
//   If the receiver stalls with a result held, non-final samples keep
//   flowing; the next frame end waits in the input register and in_if.ready
//   drops until the output register is taken.
//   Reset (rst_n low, synchronous) restores register defaults, an ambient
//   level of 1000, empty peak and saturated elapsed counters, and empties
//   both registers. cfg_we writes register cfg_index from cfg_data; write
//   only while no word is in flight.

module double_clap_detector_unit #(
  parameter int SAMPLE_BITS  = 16,
  parameter int ELAPSED_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dcd_in_if.sink                         in_if,
  dcd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [dcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                          word_valid;
  logic signed [SAMPLE_BITS-1:0] word_sample;
  logic                          word_frame_end;
  logic                          advance;
  logic                          slot_free;
  dcd_pkg::step_t                step;
  dcd_pkg::res_t                 res;

  dcd_in_stage #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_if          (in_if),
    .slot_free      (slot_free),
    .word_valid     (word_valid),
    .word_sample    (word_sample),
    .word_frame_end (word_frame_end),
    .advance        (advance)
  );

  assign step.advance = advance;
  assign step.emit    = advance && word_frame_end;

  dcd_core #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .sample    (word_sample),
    .res       (res)
  );

  dcd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res       (res),
    .slot_free (slot_free),
    .out_if    (out_if)
  );

  // a held frame end must not overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    word_valid && word_frame_end && out_if.valid && !out_if.ready |-> !advance)
    else $error("frame end advanced over a stalled result");

  // a double clap is always reported on a spike
  a_dbl_is_spike: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.spike || !out_if.double_clap))
    else $error("double clap without spike");

  // every rise of out_if.valid comes from a frame end emitted in the cycle before
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(step.emit))
    else $error("result appeared without a frame end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid && !word_valid)
    else $error("registers not empty after reset");

endmodule
